// ===== hdl/bse_pkg.sv =====
// Package for the bit-serial BCH systematic encoder: widths, mode codes, the
// minimal polynomial tables and the generator polynomials built from them.
// No dependencies; every other file of the block imports this package.
package bse_pkg;

	// Widest parity section and the bits needed to index it.
	localparam int unsigned PARITY_MAX = 192;
	localparam int unsigned IDX_W      = $clog2(PARITY_MAX);
	localparam int unsigned LEN_W      = 16;
	localparam logic [LEN_W-1:0] INFO_CAP = 16'd58192;

	// Stream widths: one byte of data on each side, one user bit on the output.
	localparam int unsigned TDATA_W = 8;

	// Configuration register indexes.
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_CODE_MODE   = 1'd0;
	localparam cfg_idx_t REG_INFO_LENGTH = 1'd1;
	localparam int unsigned CFG_DATA_W   = 16;

	// Code modes.
	typedef logic [2:0] mode_t;
	localparam mode_t MODE_N8  = 3'd0;
	localparam mode_t MODE_N10 = 3'd1;
	localparam mode_t MODE_N12 = 3'd2;
	localparam mode_t MODE_S12 = 3'd3;
	localparam mode_t MODE_M12 = 3'd4;
	localparam int unsigned NUM_MODES = 5;

	localparam mode_t           CODE_MODE_RST   = MODE_N12;
	localparam logic [LEN_W-1:0] INFO_LENGTH_RST = 16'd32208;

	// Parity length of each mode.
	localparam logic [IDX_W:0] PARITY_LEN [NUM_MODES] = '{
		9'd128, 9'd160, 9'd192, 9'd168, 9'd180
	};

	// Minimal polynomials, lowest power on the left. Short and medium rows are
	// padded with zero coefficients to a common length.
	localparam logic [0:16] MIN_NORMAL [12] = '{
		17'b10110100000000001,
		17'b11001110100000001,
		17'b10111101111100001,
		17'b10101010010110101,
		17'b11110100111110001,
		17'b10101101111011111,
		17'b10100110111101011,
		17'b11100110110011101,
		17'b10000101011100001,
		17'b11100101101011101,
		17'b10110100010111001,
		17'b11000111010110001
	};

	localparam logic [0:16] MIN_MEDIUM [12] = '{
		17'b10110100000000010,
		17'b11001001001100010,
		17'b10101010101011010,
		17'b10110110101100010,
		17'b11101011001010010,
		17'b10001011000011010,
		17'b10101101000110110,
		17'b10101010110100110,
		17'b11101101010111010,
		17'b11111001001111010,
		17'b11101000010100010,
		17'b10101000101101110
	};

	localparam logic [0:16] MIN_SHORT [12] = '{
		17'b11010100000000100,
		17'b10000010100100100,
		17'b11100010011000100,
		17'b10001001101010100,
		17'b10101010110101100,
		17'b10010001110001100,
		17'b10100111001101100,
		17'b10000100111100100,
		17'b11110000011000100,
		17'b10010010010110100,
		17'b10001000000110100,
		17'b11110111101001100
	};

	// Builds the generator of a mode as the product of its minimal polynomials
	// over GF(2). Only the coefficients below the parity length are kept, since
	// the leading term never feeds back. Evaluated at elaboration only.
	function automatic logic [PARITY_MAX-1:0] gen_poly(int unsigned mode);
		logic [255:0]            g;
		logic [255:0]            acc;
		logic [0:16]             m;
		logic [PARITY_MAX-1:0]   r;
		int unsigned             nt;
		int unsigned             p;
		g  = 256'd1;
		nt = (mode == 0) ? 8 : ((mode == 1) ? 10 : 12);
		p  = PARITY_LEN[mode];
		for (int unsigned k = 0; k < nt; k++) begin
			if (mode == 3)
				m = MIN_SHORT[k];
			else if (mode == 4)
				m = MIN_MEDIUM[k];
			else
				m = MIN_NORMAL[k];
			acc = '0;
			for (int unsigned a = 0; a < 256; a++) begin
				if (g[a]) begin
					for (int unsigned i = 0; i < 17; i++) begin
						if (m[i] && (a + i < 256))
							acc[a + i] = ~acc[a + i];
					end
				end
			end
			g = acc;
		end
		for (int unsigned b = 0; b < PARITY_MAX; b++)
			r[b] = (b < p) ? g[b] : 1'b0;
		return r;
	endfunction

	localparam logic [PARITY_MAX-1:0] GEN_TABLE [NUM_MODES] = '{
		gen_poly(0), gen_poly(1), gen_poly(2), gen_poly(3), gen_poly(4)
	};

	// Configuration as seen by the datapath.
	typedef struct packed {
		mode_t            code_mode;
		logic [LEN_W-1:0] info_length;
	} cfg_t;

	// One step of the shift register.
	typedef struct packed {
		logic en;
		logic data_bit;
	} step_t;

	// One codeword bit with its flags.
	typedef struct packed {
		logic code_bit;
		logic is_parity;
		logic frame_last;
	} result_t;

endpackage

// ===== hdl/bse_lfsr.sv =====
// Division register of the BCH encoder: parity remainder, slot counter and
// the single-step update for one codeword bit.
// Depends on bse_pkg for the generator table, widths and shared structs.
module bse_lfsr import bse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  step_t   step,
	output result_t res
);

	logic [PARITY_MAX-1:0] parity_q;
	logic [LEN_W-1:0]      slot_q;

	mode_t                 mode_eff;
	logic [LEN_W-1:0]      k_eff;
	logic [IDX_W:0]        p_len;
	logic [IDX_W-1:0]      top_idx;
	logic [PARITY_MAX-1:0] parity_cur;
	logic [PARITY_MAX-1:0] parity_nxt;
	logic [LEN_W-1:0]      slot_nxt;
	logic [LEN_W:0]        last_slot;
	logic                  top_bit;
	logic                  info_slot;
	logic                  last;
	logic                  fb;

	// Unknown modes fall back to normal t=8; long frames are clamped.
	always_comb begin
		unique case (cfg.code_mode)
			MODE_N8:  mode_eff = MODE_N8;
			MODE_N10: mode_eff = MODE_N10;
			MODE_N12: mode_eff = MODE_N12;
			MODE_S12: mode_eff = MODE_S12;
			MODE_M12: mode_eff = MODE_M12;
			default:  mode_eff = MODE_N8;
		endcase
		k_eff = (cfg.info_length > INFO_CAP) ? INFO_CAP : cfg.info_length;
	end

	// Next remainder, next slot and the outgoing bit for this slot.
	always_comb begin
		p_len      = PARITY_LEN[mode_eff];
		top_idx    = IDX_W'(p_len - 1'b1);
		parity_cur = (slot_q == '0) ? '0 : parity_q;
		top_bit    = parity_cur[top_idx];
		info_slot  = slot_q < k_eff;
		last_slot  = {1'b0, k_eff} + (LEN_W+1)'(p_len) - 1'b1;
		last       = {1'b0, slot_q} >= last_slot;
		fb         = step.data_bit ^ top_bit;
		if (info_slot) begin
			parity_nxt = {parity_cur[PARITY_MAX-2:0], 1'b0}
				^ (fb ? GEN_TABLE[mode_eff] : '0);
			slot_nxt       = slot_q + 1'b1;
			res.code_bit   = step.data_bit;
			res.is_parity  = 1'b0;
			res.frame_last = 1'b0;
		end else begin
			parity_nxt     = {parity_cur[PARITY_MAX-2:0], 1'b0};
			slot_nxt       = last ? '0 : slot_q + 1'b1;
			res.code_bit   = top_bit;
			res.is_parity  = 1'b1;
			res.frame_last = last;
		end
	end

	// State advances once for every bit that moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= '0;
			slot_q   <= '0;
		end else if (step.en) begin
			parity_q <= parity_nxt;
			slot_q   <= slot_nxt;
		end
	end

endmodule

// ===== hdl/bch_systematic_encoder_core.sv =====
// Top level of the bit-serial BCH systematic encoder: stream ports,
// configuration registers, input and result registers around bse_lfsr.
// Depends on bse_pkg and bse_lfsr.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   input    | s_tvalid s_tready s_tdata            | slave
//   output   | m_tvalid m_tready m_tdata m_tuser    | master
//            | m_tlast                              |
//   config   | cfg_we cfg_index cfg_data            | write only
//
// One bit per clock cycle sustained while m_tready is held high; each bit
// passes through the input register, then the result register, on its way
// to the output. Reset clears the remainder, slot counter and valid flags
// and loads the configuration defaults (normal t=12, 32208 info bits). A
// stall at the output holds both stages; the input side keeps taking bits
// while a stage is free.
module bch_systematic_encoder_core import bse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream. s_tdata bits: [0] data_bit, [7:1] zero.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_W-1:0]    s_tdata,
	// Output stream. m_tdata bits: [0] code_bit, [7:1] zero.
	// m_tuser bits: [0] is_parity. m_tlast: frame_last.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,
	output logic [0:0]            m_tuser,
	output logic                  m_tlast,
	// Configuration write port.
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	logic    valid_s1;
	logic    data_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res;
	step_t   step;
	logic    adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_mode   <= CODE_MODE_RST;
			cfg_q.info_length <= INFO_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CODE_MODE:   cfg_q.code_mode   <= cfg_data[2:0];
				REG_INFO_LENGTH: cfg_q.info_length <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the result stage moves when empty or taken, the input stage
	// when empty or when its bit moves on.
	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign step.en       = valid_s1 && adv;
	assign step.data_bit = data_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			data_s1 <= s_tdata[0];
	end

	bse_lfsr u_lfsr (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (step),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step.en)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(TDATA_W-1){1'b0}}, res_s2.code_bit};
	assign m_tuser  = res_s2.is_parity;
	assign m_tlast  = res_s2.frame_last;

endmodule
